// File: src/tdc_pkg.sv
//------------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants for the totient and divisor count block.
//------------------------------------------------------------------------------
package tdc_pkg;

	localparam int unsigned DCOUNT_BITS = 11;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} tdc_div_stat_t;

	typedef struct packed {
		logic init;
		logic step;
	} tdc_cand_ctrl_t;

endpackage

// File: src/totient_and_divisor_count.sv
//------------------------------------------------------------------------------
// totient_and_divisor_count
// Euler totient, divisor count and their combined value by trial division.
//------------------------------------------------------------------------------
// One transaction in gives one transaction out: totient phi(n), divisor count
// d(n) and n - phi(n) - d(n) + 1 (all zero for an input of zero). Items are
// handled one at a time; the input is accepted again as soon as the result
// has gone to the output register. Each trial division runs on a single
// bit-serial divider, and an item takes one division for every candidate
// 2, 3, 5, 7, ... up to the square root of the remaining cofactor, plus, for
// each prime factor found, one more division for every time it divides out
// and one of the totient, and one division for a cofactor left over at the
// end. The worst case is a prime near 2^VALUE_BITS: about 23000 divisions at
// the default.
module totient_and_divisor_count
	import tdc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 31
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// value_in
	input  logic [((VALUE_BITS+7)/8)*8-1:0]              s_tdata,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// totient, divisor_count, combined
	output logic [((2*VALUE_BITS+DCOUNT_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned OUT_W     = ((2*VALUE_BITS+DCOUNT_BITS+7)/8)*8;
	localparam int unsigned CAND_BITS = (VALUE_BITS + 1) / 2 + 1;
	localparam int unsigned EXP_BITS  = $clog2(VALUE_BITS + 1);
	// The divisor count never exceeds twice the square root of the input.
	localparam int unsigned CNT_W     = (CAND_BITS > DCOUNT_BITS) ? CAND_BITS : DCOUNT_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEST,
		S_DREST,
		S_DTOT,
		S_TAIL,
		S_DTAIL,
		S_COMB
	} state_t;

	state_t                 state_q;
	logic [VALUE_BITS-1:0]  n_q;
	logic [VALUE_BITS-1:0]  rest_q;
	logic [VALUE_BITS-1:0]  tot_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [EXP_BITS-1:0]    exp_q;
	logic                   zero_q;
	logic [VALUE_BITS-1:0]  out_tot_q;
	logic [DCOUNT_BITS-1:0] out_dc_q;
	logic [VALUE_BITS-1:0]  out_comb_q;
	logic                   m_tvalid_q;

	logic                   div_start;
	logic [VALUE_BITS-1:0]  div_dividend;
	logic [VALUE_BITS-1:0]  div_divisor;
	logic [VALUE_BITS-1:0]  div_quo;
	tdc_div_stat_t          div_stat;

	tdc_cand_ctrl_t         cand_ctrl;
	logic [CAND_BITS-1:0]   cand;
	logic [CAND_BITS-1:0]   cand_next;
	logic [VALUE_BITS:0]    sq;
	logic [VALUE_BITS:0]    sq_next;

	logic                   in_xfer;
	logic                   out_free;
	logic [CNT_W-1:0]       exp_inc;
	logic [VALUE_BITS-1:0]  comb_val;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign exp_inc  = CNT_W'(exp_q) + CNT_W'(1);
	assign comb_val = n_q + VALUE_BITS'(1) - tot_q - VALUE_BITS'(cnt_q);

	always_comb begin
		div_start      = 1'b0;
		div_dividend   = rest_q;
		div_divisor    = VALUE_BITS'(cand);
		cand_ctrl.init = in_xfer;
		cand_ctrl.step = 1'b0;
		unique case (state_q)
			S_TEST: begin
				div_start = !zero_q && ({1'b0, rest_q} >= sq);
			end
			S_DREST: begin
				if (div_stat.done) begin
					if (div_stat.rem_zero) begin
						div_start = 1'b1;
						if (exp_q == '0) begin
							div_dividend = tot_q;
						end else begin
							div_dividend = div_quo;
						end
					end else begin
						cand_ctrl.step = 1'b1;
						div_divisor    = VALUE_BITS'(cand_next);
						div_start      = ({1'b0, rest_q} >= sq_next);
					end
				end
			end
			S_DTOT: begin
				div_start = div_stat.done;
			end
			S_TAIL: begin
				div_start    = (rest_q > VALUE_BITS'(1));
				div_dividend = tot_q;
				div_divisor  = rest_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_COMB && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					if (zero_q) begin
						state_q <= S_COMB;
					end else if (div_start) begin
						state_q <= S_DREST;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_DREST: begin
					if (div_stat.done) begin
						if (div_stat.rem_zero) begin
							if (exp_q == '0) begin
								state_q <= S_DTOT;
							end
						end else if (!div_start) begin
							state_q <= S_TAIL;
						end
					end
				end
				S_DTOT: begin
					if (div_stat.done) begin
						state_q <= S_DREST;
					end
				end
				S_TAIL: begin
					state_q <= div_start ? S_DTAIL : S_COMB;
				end
				S_DTAIL: begin
					if (div_stat.done) begin
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q    <= s_tdata[VALUE_BITS-1:0];
			rest_q <= s_tdata[VALUE_BITS-1:0];
			tot_q  <= s_tdata[VALUE_BITS-1:0];
			zero_q <= (s_tdata[VALUE_BITS-1:0] == '0);
			cnt_q  <= CNT_W'(1);
			exp_q  <= '0;
		end
		if (state_q == S_DREST && div_stat.done) begin
			if (div_stat.rem_zero) begin
				rest_q <= div_quo;
				exp_q  <= exp_q + EXP_BITS'(1);
			end else begin
				if (exp_q != '0) begin
					cnt_q <= CNT_W'(cnt_q * exp_inc);
				end
				exp_q <= '0;
			end
		end
		if ((state_q == S_DTOT || state_q == S_DTAIL) && div_stat.done) begin
			tot_q <= tot_q - div_quo;
		end
		if (state_q == S_TAIL && div_start) begin
			cnt_q <= {cnt_q[CNT_W-2:0], 1'b0};
		end
		if (state_q == S_COMB && out_free) begin
			out_tot_q  <= zero_q ? '0 : tot_q;
			out_dc_q   <= zero_q ? '0 : cnt_q[DCOUNT_BITS-1:0];
			out_comb_q <= zero_q ? '0 : comb_val;
		end
	end

	tdc_divider #(
		.VALUE_BITS (VALUE_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	tdc_cand #(
		.VALUE_BITS (VALUE_BITS),
		.CAND_BITS  (CAND_BITS)
	) u_cand (
		.clk       (clk),
		.ctrl      (cand_ctrl),
		.cand      (cand),
		.cand_next (cand_next),
		.sq        (sq),
		.sq_next   (sq_next)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({out_comb_q, out_dc_q, out_tot_q});

endmodule

// File: src/tdc_divider.sv
//------------------------------------------------------------------------------
// tdc_divider
// Bit-serial restoring divider: one quotient bit per cycle.
//------------------------------------------------------------------------------
module tdc_divider
	import tdc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic [VALUE_BITS-1:0] quotient,
	output tdc_div_stat_t         stat
);

	localparam int unsigned CNT_BITS = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   diff;

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[VALUE_BITS]) begin
				rem_q <= diff[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient      = quo_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

// File: src/tdc_cand.sv
//------------------------------------------------------------------------------
// tdc_cand
// Trial divisor stepper: holds the candidate and its square, 2 then odd values.
//------------------------------------------------------------------------------
module tdc_cand
	import tdc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 31,
	parameter int unsigned CAND_BITS  = (VALUE_BITS + 1) / 2 + 1
) (
	input  logic                 clk,
	input  tdc_cand_ctrl_t       ctrl,
	output logic [CAND_BITS-1:0] cand,
	output logic [CAND_BITS-1:0] cand_next,
	output logic [VALUE_BITS:0]  sq,
	output logic [VALUE_BITS:0]  sq_next
);

	logic [CAND_BITS-1:0] cand_q;
	logic [VALUE_BITS:0]  sq_q;
	logic                 is_two;

	assign is_two    = (cand_q == CAND_BITS'(2));
	assign cand_next = is_two ? CAND_BITS'(3) : cand_q + CAND_BITS'(2);
	assign sq_next   = is_two ? (VALUE_BITS+1)'(9)
	                 : sq_q + (VALUE_BITS+1)'({cand_q, 2'b00}) + (VALUE_BITS+1)'(4);

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			cand_q <= CAND_BITS'(2);
			sq_q   <= (VALUE_BITS+1)'(4);
		end else if (ctrl.step) begin
			cand_q <= cand_next;
			sq_q   <= sq_next;
		end
	end

	assign cand = cand_q;
	assign sq   = sq_q;

endmodule

// File: src/tdc_checker.sv
//------------------------------------------------------------------------------
// tdc_checker
// Port-level checks for the totient and divisor count block.
//------------------------------------------------------------------------------
module tdc_checker
	import tdc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 31
) (
	input logic                                         clk,
	input logic                                         arst_n,
	input logic                                         s_tvalid,
	input logic                                         s_tready,
	input logic [((VALUE_BITS+7)/8)*8-1:0]              s_tdata,
	input logic                                         m_tvalid,
	input logic                                         m_tready,
	input logic [((2*VALUE_BITS+DCOUNT_BITS+7)/8)*8-1:0] m_tdata
);

	logic [VALUE_BITS-1:0]  tot;
	logic [DCOUNT_BITS-1:0] dc;
	logic [VALUE_BITS-1:0]  comb;
	logic                   in_zero;

	assign tot     = m_tdata[VALUE_BITS-1:0];
	assign dc      = m_tdata[VALUE_BITS+DCOUNT_BITS-1:VALUE_BITS];
	assign comb    = m_tdata[2*VALUE_BITS+DCOUNT_BITS-1:VALUE_BITS+DCOUNT_BITS];
	assign in_zero = (s_tdata[VALUE_BITS-1:0] == '0);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result changed or vanished while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Second transaction accepted while one is in progress.");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("Result appeared one cycle after its input.");

	a_zero_totient: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && tot == '0 |-> dc == '0 && comb == '0)
		else $error("Zero totient with non-zero companion fields.");

	a_zero_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && in_zero && !m_tvalid |=> ##2 m_tvalid)
		else $error("Zero input did not give its result promptly.");

endmodule

bind totient_and_divisor_count tdc_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_tdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
